/* src/rsi_pkg.sv */
// Shared constants and register codes for the ray / unit-sphere intersect pipeline.
// No dependencies; every other file in src imports this package.
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // Pipelined square root: two radicand bits per stage over a 64-bit radicand.
  localparam int SQRT_STAGES = 32;
  // Pipelined restoring divider: one quotient bit per stage.
  localparam int DIV_STAGES  = 32;

  // Fixed-point 1.0 squared, the sphere radius term of the discriminant.
  localparam logic [63:0] ONE_SQ = 64'(1) << (2 * FRAC_BITS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_M00_M01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M02_TX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M10_M11 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M12_TY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_M20_M21 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_M22_TZ  = 3'd5;

  localparam logic [CFG_W-1:0] RST_M00_M01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_M02_TX  = 64'h0;
  localparam logic [CFG_W-1:0] RST_M10_M11 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] RST_M12_TY  = 64'h0;
  localparam logic [CFG_W-1:0] RST_M20_M21 = 64'h0;
  localparam logic [CFG_W-1:0] RST_M22_TZ  = 64'h0001_0000_0000_0000;

endpackage

/* src/rsi_if.sv */
// Valid/ready channel interfaces for ray input and intersect result.
// Depends on rsi_pkg for the coordinate width.
interface rsi_in_if;
  import rsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] origin_z;
  logic [COORD_W-1:0] dir_x;
  logic [COORD_W-1:0] dir_y;
  logic [COORD_W-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_out_if;
  import rsi_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [COORD_W-1:0] distance;
  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

/* src/rsi_xform.sv */
// Four-stage affine inverse map of ray origin and direction, plus the squared lengths.
// Depends on rsi_pkg.
module rsi_xform (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic                                        in_vld,
  input  logic [2:0][rsi_pkg::COORD_W-1:0]            org,
  input  logic [2:0][rsi_pkg::COORD_W-1:0]            dir,
  input  logic [rsi_pkg::CFG_REGS-1:0][rsi_pkg::CFG_W-1:0] inv,
  output logic                                        out_vld,
  output logic [2:0][rsi_pkg::COORD_W-1:0]            p,
  output logic [2:0]                                  vneg,
  output logic [2:0][rsi_pkg::COORD_W-1:0]            vm,
  output logic [63:0]                                 sp,
  output logic [63:0]                                 sv,
  output logic [63:0]                                 sd
);
  import rsi_pkg::*;

  logic [3:0] vld_r;

  logic [2:0][2:0][COORD_W-1:0] m;
  logic [2:0][COORD_W-1:0]      tr;

  // stage 1: products
  logic signed [63:0] po_nxt [3][3];
  logic signed [63:0] pd_nxt [3][3];
  logic [63:0]        dsq_nxt [3];
  logic signed [63:0] po_r [3][3];
  logic signed [63:0] pd_r [3][3];
  logic [63:0]        dsq_r [3];

  // stage 2: row sums, saturated
  logic [2:0][COORD_W-1:0] p2_nxt, v2_nxt;
  logic [63:0]             sd2_nxt;
  logic [2:0][COORD_W-1:0] p2_r, v2_r;
  logic [63:0]             sd2_r;

  // stage 3: magnitudes and squares
  logic [2:0][COORD_W-1:0] pm3, vm3;
  logic [63:0]             psq_nxt [3];
  logic [63:0]             vsq_nxt [3];
  logic [63:0]             psq_r [3];
  logic [63:0]             vsq_r [3];
  logic [2:0][COORD_W-1:0] p3_r, vm3_r;
  logic [2:0]              vneg3_r;
  logic [63:0]             sd3_r;

  // stage 4: sums of squares
  logic [2:0][COORD_W-1:0] p4_r, vm4_r;
  logic [2:0]              vneg4_r;
  logic [63:0]             sp4_r, sv4_r, sd4_r;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [63:0] s);
    logic [COORD_W-1:0] res;
    if (s > 64'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (s < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = s[COORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] x);
    return x[COORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m[r][0] = inv[2*r][63:32];
      m[r][1] = inv[2*r][31:0];
      m[r][2] = inv[2*r+1][63:32];
      tr[r]   = inv[2*r+1][31:0];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        po_nxt[r][c] = $signed(m[r][c]) * $signed(org[c]);
        pd_nxt[r][c] = $signed(m[r][c]) * $signed(dir[c]);
      end
      dsq_nxt[r] = mag(dir[r]) * mag(dir[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p2_nxt[r] = sat32((po_r[r][0] >>> FRAC_BITS) + (po_r[r][1] >>> FRAC_BITS)
                        + (po_r[r][2] >>> FRAC_BITS) + 64'($signed(tr[r])));
      v2_nxt[r] = sat32((pd_r[r][0] >>> FRAC_BITS) + (pd_r[r][1] >>> FRAC_BITS)
                        + (pd_r[r][2] >>> FRAC_BITS));
    end
    sd2_nxt = dsq_r[0] + dsq_r[1] + dsq_r[2];
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pm3[r]     = mag(p2_r[r]);
      vm3[r]     = mag(v2_r[r]);
      psq_nxt[r] = pm3[r] * pm3[r];
      vsq_nxt[r] = vm3[r] * vm3[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          po_r[r][c] <= po_nxt[r][c];
          pd_r[r][c] <= pd_nxt[r][c];
        end
        dsq_r[r] <= dsq_nxt[r];
        psq_r[r] <= psq_nxt[r];
        vsq_r[r] <= vsq_nxt[r];
        vneg3_r[r] <= v2_r[r][COORD_W-1];
      end
      p2_r    <= p2_nxt;
      v2_r    <= v2_nxt;
      sd2_r   <= sd2_nxt;
      p3_r    <= p2_r;
      vm3_r   <= vm3;
      sd3_r   <= sd2_r;
      p4_r    <= p3_r;
      vm4_r   <= vm3_r;
      vneg4_r <= vneg3_r;
      sp4_r   <= psq_r[0] + psq_r[1] + psq_r[2];
      sv4_r   <= vsq_r[0] + vsq_r[1] + vsq_r[2];
      sd4_r   <= sd3_r;
    end
  end

  assign out_vld = vld_r[3];
  assign p       = p4_r;
  assign vneg    = vneg4_r;
  assign vm      = vm4_r;
  assign sp      = sp4_r;
  assign sv      = sv4_r;
  assign sd      = sd4_r;

endmodule

/* src/rsi_isqrt.sv */
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit radicand, one root bit per stage.
// Depends on rsi_pkg for the stage count.
module rsi_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);
  import rsi_pkg::*;

  localparam logic [63:0] BIT_TOP = 64'h4000_0000_0000_0000;

  logic [63:0] x_r   [SQRT_STAGES];
  logic [63:0] r_r   [SQRT_STAGES];
  logic [63:0] x_nxt [SQRT_STAGES];
  logic [63:0] r_nxt [SQRT_STAGES];

  always_comb begin
    logic [63:0] xi, ri, bt, trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      xi    = (k == 0) ? x : x_r[(k == 0) ? 0 : k - 1];
      ri    = (k == 0) ? 64'h0 : r_r[(k == 0) ? 0 : k - 1];
      bt    = BIT_TOP >> (2 * k);
      trial = ri + bt;
      if (xi >= trial) begin
        x_nxt[k] = xi - trial;
        r_nxt[k] = (ri >> 1) + bt;
      end else begin
        x_nxt[k] = xi;
        r_nxt[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        x_r[k] <= x_nxt[k];
        r_r[k] <= r_nxt[k];
      end
    end
  end

  assign root = r_r[SQRT_STAGES-1][31:0];

endmodule

/* src/rsi_div.sv */
// Pipelined restoring divider: ({rem_in, num_lo}) / den, 32 quotient bits, rem_in < den.
// Depends on rsi_pkg for the stage count.
module rsi_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] rem_in,
  input  logic [31:0] num_lo,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import rsi_pkg::*;

  logic [31:0] rem_r   [DIV_STAGES];
  logic [31:0] num_r   [DIV_STAGES];
  logic [31:0] den_r   [DIV_STAGES];
  logic [31:0] q_r     [DIV_STAGES];
  logic [31:0] rem_nxt [DIV_STAGES];
  logic [31:0] num_nxt [DIV_STAGES];
  logic [31:0] q_nxt   [DIV_STAGES];

  always_comb begin
    logic [31:0] ri, ni, di, qi;
    logic [32:0] rem2;
    for (int k = 0; k < DIV_STAGES; k++) begin
      ri   = (k == 0) ? rem_in : rem_r[(k == 0) ? 0 : k - 1];
      ni   = (k == 0) ? num_lo : num_r[(k == 0) ? 0 : k - 1];
      di   = (k == 0) ? den    : den_r[(k == 0) ? 0 : k - 1];
      qi   = (k == 0) ? 32'h0  : q_r[(k == 0) ? 0 : k - 1];
      rem2 = {ri, ni[31]};
      if (rem2 >= {1'b0, di}) begin
        rem_nxt[k] = 32'(rem2 - {1'b0, di});
        q_nxt[k]   = {qi[30:0], 1'b1};
      end else begin
        rem_nxt[k] = rem2[31:0];
        q_nxt[k]   = {qi[30:0], 1'b0};
      end
      num_nxt[k] = {ni[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        den_r[k] <= (k == 0) ? den : den_r[(k == 0) ? 0 : k - 1];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

/* src/ray_sphere_intersect_unit.sv */
// Top level of the ray / unit-sphere intersect pipeline.
// Depends on rsi_pkg, rsi_if, rsi_xform, rsi_isqrt and rsi_div.
//
// Usage:
//   in_ch  : valid/ready channel carrying one world-space ray (origin, direction, Q16.16).
//   out_ch : valid/ready channel carrying hit and the saturated world distance (0 on miss).
//   cfg_*  : write-only port for the six inverse-transform registers; write only while idle.
// Throughput: one ray per clock while the skid register is empty. Every unit (multipliers,
//   square roots, dividers) is fully pipelined, so nothing is shared between rays.
// Path: an accepted ray passes in order through the transform, the |v| root, the
//   normalize divide, the dot product and discriminant, the discriminant root, root select
//   and product, the distance divide and the final result register before out_ch.valid.
// Reset: rst_n low for one clock clears every valid bit and loads the identity transform.
// Stall: when out_ch.ready is low, the finished result drops into a one-entry skid register
//   and the pipeline keeps advancing for that cycle; while the skid holds a result the whole
//   pipeline holds, in_ch.ready is low, and nothing is lost or repeated.
//   in_ch.ready depends only on registered state.
module ray_sphere_intersect_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  rsi_in_if.sink                             in_ch,
  rsi_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rsi_pkg::CFG_W-1:0]          cfg_wdata
);
  import rsi_pkg::*;

  localparam int VN_W   = FRAC_BITS + 2;   // signed normalized direction component
  localparam int PROD_W = VN_W + COORD_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int TS_W   = 35;              // signed root candidates
  localparam int SPLIT  = 17;              // partial product split of t
  localparam logic signed [DOT_W-1:0] B_MAX = DOT_W'(64'hFFFF_FFFF);
  localparam logic signed [DOT_W-1:0] B_MIN = -B_MAX;

  // Sideband carried beside the |v| and |dir| roots.
  typedef struct packed {
    logic                    vld;
    logic [2:0][COORD_W-1:0] p;
    logic [2:0]              vneg;
    logic [2:0][COORD_W-1:0] vm;
    logic [63:0]             sp;
  } sb_root_t;

  // Sideband carried beside the normalizing dividers.
  typedef struct packed {
    logic                    vld;
    logic                    miss;
    logic [2:0][COORD_W-1:0] p;
    logic [2:0]              vneg;
    logic [63:0]             sp;
    logic [31:0]             lv;
    logic [31:0]             lw;
  } sb_norm_t;

  // Sideband carried beside the discriminant root.
  typedef struct packed {
    logic        vld;
    logic        miss;
    logic [32:0] b;
    logic [31:0] lv;
    logic [31:0] lw;
  } sb_disc_t;

  // Sideband carried beside the distance divider.
  typedef struct packed {
    logic vld;
    logic miss;
    logic sat;
  } sb_dist_t;

  logic en;

  // ---------------------------------------------------------------- configuration
  logic [CFG_REGS-1:0][CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[CFG_M00_M01] <= RST_M00_M01;
      cfg_r[CFG_M02_TX]  <= RST_M02_TX;
      cfg_r[CFG_M10_M11] <= RST_M10_M11;
      cfg_r[CFG_M12_TY]  <= RST_M12_TY;
      cfg_r[CFG_M20_M21] <= RST_M20_M21;
      cfg_r[CFG_M22_TZ]  <= RST_M22_TZ;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_M00_M01: cfg_r[CFG_M00_M01] <= cfg_wdata;
        CFG_M02_TX:  cfg_r[CFG_M02_TX]  <= cfg_wdata;
        CFG_M10_M11: cfg_r[CFG_M10_M11] <= cfg_wdata;
        CFG_M12_TY:  cfg_r[CFG_M12_TY]  <= cfg_wdata;
        CFG_M20_M21: cfg_r[CFG_M20_M21] <= cfg_wdata;
        CFG_M22_TZ:  cfg_r[CFG_M22_TZ]  <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------- transform
  logic                    x_vld;
  logic [2:0][COORD_W-1:0] x_p, x_vm;
  logic [2:0]              x_vneg;
  logic [63:0]             x_sp, x_sv, x_sd;

  rsi_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .org     ({in_ch.origin_z, in_ch.origin_y, in_ch.origin_x}),
    .dir     ({in_ch.dir_z, in_ch.dir_y, in_ch.dir_x}),
    .inv     (cfg_r),
    .out_vld (x_vld),
    .p       (x_p),
    .vneg    (x_vneg),
    .vm      (x_vm),
    .sp      (x_sp),
    .sv      (x_sv),
    .sd      (x_sd)
  );

  // ---------------------------------------------------------------- lengths |v| and |dir|
  logic [31:0] lv_root, lw_root;
  sb_root_t    sb_root_r [SQRT_STAGES];

  rsi_isqrt u_sqrt_v (.clk(clk), .en(en), .x(x_sv), .root(lv_root));
  rsi_isqrt u_sqrt_w (.clk(clk), .en(en), .x(x_sd), .root(lw_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) sb_root_r[k].vld <= 1'b0;
    end else if (en) begin
      sb_root_r[0] <= '{vld: x_vld, p: x_p, vneg: x_vneg, vm: x_vm, sp: x_sp};
      for (int k = 1; k < SQRT_STAGES; k++) sb_root_r[k] <= sb_root_r[k-1];
    end
  end

  // ---------------------------------------------------------------- normalize direction
  sb_root_t    rt;
  logic [31:0] vn_q [3];
  sb_norm_t    sb_norm_r [DIV_STAGES];

  assign rt = sb_root_r[SQRT_STAGES-1];

  // |v_i| << FRAC_BITS split into a high remainder and a low word; |v_i| <= lv keeps the
  // high part below the divisor.
  for (genvar i = 0; i < 3; i++) begin : g_norm
    rsi_div u_div_n (
      .clk    (clk),
      .en     (en),
      .rem_in (32'(rt.vm[i] >> (COORD_W - FRAC_BITS))),
      .num_lo (32'(rt.vm[i] << FRAC_BITS)),
      .den    (lv_root),
      .quo    (vn_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) sb_norm_r[k].vld <= 1'b0;
    end else if (en) begin
      // a zero-length object direction is a miss
      sb_norm_r[0] <= '{vld: rt.vld, miss: (lv_root == 32'h0), p: rt.p, vneg: rt.vneg,
                        sp: rt.sp, lv: lv_root, lw: lw_root};
      for (int k = 1; k < DIV_STAGES; k++) sb_norm_r[k] <= sb_norm_r[k-1];
    end
  end

  // ---------------------------------------------------------------- dot product and discriminant
  sb_norm_t nt;
  logic signed [VN_W-1:0]   vn [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic        d1_vld_r, d1_miss_r;
  logic [63:0] d1_sp_r;
  logic [31:0] d1_lv_r, d1_lw_r;

  assign nt = sb_norm_r[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vn[i]       = nt.vneg[i] ? -VN_W'(vn_q[i]) : VN_W'(vn_q[i]);
      prod_nxt[i] = vn[i] * $signed(nt.p[i]);
    end
  end

  // b = floor(dot / 2^F), clamped to +/-(2^32 - 1)
  logic signed [DOT_W-1:0] dot, b_full;
  logic signed [32:0]      b_nxt;
  logic [31:0]             bm_nxt;
  logic signed [32:0]      d2_b_r;
  logic [31:0]             d2_bm_r;
  logic                    d2_vld_r, d2_miss_r;
  logic [63:0]             d2_sp_r;
  logic [31:0]             d2_lv_r, d2_lw_r;

  always_comb begin
    dot    = DOT_W'(prod_r[0]) + DOT_W'(prod_r[1]) + DOT_W'(prod_r[2]);
    b_full = dot >>> FRAC_BITS;
    if (b_full > B_MAX) begin
      b_nxt = 33'(B_MAX);
    end else if (b_full < B_MIN) begin
      b_nxt = 33'(B_MIN);
    end else begin
      b_nxt = 33'(b_full);
    end
    bm_nxt = b_nxt[32] ? 32'(-b_nxt) : 32'(b_nxt);
  end

  logic [63:0]        d3_b2_r, d3_sp_r;
  logic signed [32:0] d3_b_r;
  logic               d3_vld_r, d3_miss_r;
  logic [31:0]        d3_lv_r, d3_lw_r;

  // h = b^2 + 1 - |p|^2; a shortfall beyond 1.0 means no real root
  logic [63:0] diff, h_nxt;
  logic        h_miss;

  always_comb begin
    diff   = 64'h0;
    h_miss = 1'b0;
    if (d3_sp_r > d3_b2_r) begin
      diff   = d3_sp_r - d3_b2_r;
      h_miss = (diff > ONE_SQ);
      h_nxt  = ONE_SQ - diff;
    end else begin
      diff  = d3_b2_r - d3_sp_r;
      h_nxt = (diff > ~ONE_SQ) ? '1 : diff + ONE_SQ;
    end
  end

  logic [63:0] d4_h_r;
  sb_disc_t    d4_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r    <= 1'b0;
      d2_vld_r    <= 1'b0;
      d3_vld_r    <= 1'b0;
      d4_sb_r.vld <= 1'b0;
    end else if (en) begin
      d1_vld_r  <= nt.vld;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
      d4_sb_r   <= '{vld: d3_vld_r, miss: d3_miss_r | h_miss, b: d3_b_r,
                     lv: d3_lv_r, lw: d3_lw_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) prod_r[i] <= prod_nxt[i];
      d1_miss_r <= nt.miss;
      d1_sp_r   <= nt.sp;
      d1_lv_r   <= nt.lv;
      d1_lw_r   <= nt.lw;
      d2_b_r    <= b_nxt;
      d2_bm_r   <= bm_nxt;
      d2_miss_r <= d1_miss_r;
      d2_sp_r   <= d1_sp_r;
      d2_lv_r   <= d1_lv_r;
      d2_lw_r   <= d1_lw_r;
      d3_b2_r   <= d2_bm_r * d2_bm_r;
      d3_b_r    <= d2_b_r;
      d3_miss_r <= d2_miss_r;
      d3_sp_r   <= d2_sp_r;
      d3_lv_r   <= d2_lv_r;
      d3_lw_r   <= d2_lw_r;
      d4_h_r    <= h_nxt;
    end
  end

  // ---------------------------------------------------------------- discriminant root
  logic [31:0] sq;
  sb_disc_t    sb_disc_r [SQRT_STAGES];

  rsi_isqrt u_sqrt_h (.clk(clk), .en(en), .x(d4_h_r), .root(sq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) sb_disc_r[k].vld <= 1'b0;
    end else if (en) begin
      sb_disc_r[0] <= d4_sb_r;
      for (int k = 1; k < SQRT_STAGES; k++) sb_disc_r[k] <= sb_disc_r[k-1];
    end
  end

  // ---------------------------------------------------------------- nearest root ahead
  sb_disc_t dt;
  logic signed [TS_W-1:0] bx, sqx, t0, t1;
  logic [33:0] t_nxt;
  logic        t_miss;

  assign dt = sb_disc_r[SQRT_STAGES-1];

  always_comb begin
    bx     = TS_W'($signed(dt.b));
    sqx    = $signed({3'b000, sq});
    t0     = -bx - sqx;
    t1     = -bx + sqx;
    t_miss = t1[TS_W-1];
    // origin inside the sphere: near root is behind, take the far one
    t_nxt  = t0[TS_W-1] ? t1[33:0] : t0[33:0];
  end

  logic [33:0] t1_t_r;
  logic [31:0] t1_lv_r, t1_lw_r;
  logic        t1_vld_r, t1_miss_r;

  logic [48:0] t2_lo_r, t2_hi_r;
  logic [31:0] t2_lv_r;
  logic        t2_vld_r, t2_miss_r;

  logic [65:0] t3_ab_r;
  logic [31:0] t3_lv_r;
  logic        t3_vld_r, t3_miss_r;

  logic [31:0] t4_rem_r, t4_num_r, t4_lv_r;
  sb_dist_t    t4_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r    <= 1'b0;
      t2_vld_r    <= 1'b0;
      t3_vld_r    <= 1'b0;
      t4_sb_r.vld <= 1'b0;
    end else if (en) begin
      t1_vld_r     <= dt.vld;
      t2_vld_r     <= t1_vld_r;
      t3_vld_r     <= t2_vld_r;
      t4_sb_r.vld  <= t3_vld_r;
      // a quotient of 2^32 or more saturates
      t4_sb_r.sat  <= (t3_ab_r[65:32] >= {2'b00, t3_lv_r});
      t4_sb_r.miss <= t3_miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_t_r    <= t_nxt;
      t1_lv_r   <= dt.lv;
      t1_lw_r   <= dt.lw;
      t1_miss_r <= dt.miss | t_miss;
      // t * |dir| in two 17 x 32 partial products
      t2_lo_r   <= t1_t_r[SPLIT-1:0] * t1_lw_r;
      t2_hi_r   <= t1_t_r[33:SPLIT] * t1_lw_r;
      t2_lv_r   <= t1_lv_r;
      t2_miss_r <= t1_miss_r;
      t3_ab_r   <= 66'(t2_lo_r) + (66'(t2_hi_r) << SPLIT);
      t3_lv_r   <= t2_lv_r;
      t3_miss_r <= t2_miss_r;
      // the high word seeds the divider
      t4_rem_r     <= t3_ab_r[63:32];
      t4_num_r     <= t3_ab_r[31:0];
      t4_lv_r      <= t3_lv_r;
    end
  end

  // ---------------------------------------------------------------- world distance
  logic [31:0] dq;
  sb_dist_t    sb_dist_r [DIV_STAGES];
  sb_dist_t    qt;

  rsi_div u_div_d (
    .clk    (clk),
    .en     (en),
    .rem_in (t4_rem_r),
    .num_lo (t4_num_r),
    .den    (t4_lv_r),
    .quo    (dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) sb_dist_r[k].vld <= 1'b0;
    end else if (en) begin
      sb_dist_r[0] <= t4_sb_r;
      for (int k = 1; k < DIV_STAGES; k++) sb_dist_r[k] <= sb_dist_r[k-1];
    end
  end

  assign qt = sb_dist_r[DIV_STAGES-1];

  // ---------------------------------------------------------------- result and skid
  logic        f_vld_r, f_hit_r;
  logic [31:0] f_dist_r, dist_nxt;
  logic        skid_full_r, skid_hit_r;
  logic [31:0] skid_dist_r;

  always_comb begin
    // quotient plus one LSB, saturating at all ones
    if (qt.sat || dq >= 32'hFFFF_FFFE) begin
      dist_nxt = 32'hFFFF_FFFF;
    end else begin
      dist_nxt = dq + 32'h1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= qt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_hit_r  <= ~qt.miss;
      f_dist_r <= qt.miss ? 32'h0 : dist_nxt;
    end
  end

  // Park a stalled result in the skid register instead of holding the pipeline at once;
  // hold everything while the skid register is occupied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ch.ready) skid_full_r <= 1'b0;
    end else if (f_vld_r && !out_ch.ready) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_hit_r  <= f_hit_r;
      skid_dist_r <= f_dist_r;
    end
  end

  assign en              = ~skid_full_r;
  assign in_ch.ready     = en;
  assign out_ch.valid    = skid_full_r | f_vld_r;
  assign out_ch.hit      = skid_full_r ? skid_hit_r : f_hit_r;
  assign out_ch.distance = skid_full_r ? skid_dist_r : f_dist_r;

endmodule

/* sim/ray_sphere_intersect_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ray_sphere_intersect_unit: rays in, hit/distance out.
// Depends on rsi_pkg, rsi_if and the RTL in src; holds its own fixed-point predictor.
module ray_sphere_intersect_unit_tb;
  import rsi_pkg::*;

  localparam int LATENCY = 141;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    logic [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [31:0] distance;
  } isect_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  rsi_in_if  in_if ();
  rsi_out_if out_if ();

  ray_sphere_intersect_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the inverse-transform registers, updated on every in-range write.
  logic [CFG_W-1:0] xform_regs [CFG_REGS];
  isect_t pending_hits[$];

  int n_rays;
  int n_results;
  int n_hit_results;
  int n_mismatch;
  bit sender_idle;
  bit receiver_idle;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: object-space mapping, unit-sphere quadratic, world distance.
  // ---------------------------------------------------------------------------

  // One row of the affine inverse; each product is floored before the sum.
  function automatic longint xform_row(logic [63:0] r01, logic [63:0] r2t,
                                       longint x0, longint x1, longint x2, bit is_point);
    longint s;
    s = ((longint'(signed'(r01[63:32])) * x0) >>> FRAC_BITS)
      + ((longint'(signed'(r01[31:0])) * x1) >>> FRAC_BITS)
      + ((longint'(signed'(r2t[63:32])) * x2) >>> FRAC_BITS);
    if (is_point) s += longint'(signed'(r2t[31:0]));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic logic [63:0] mag_sq(longint a, longint b, longint c);
    logic [63:0] ma, mb, mc;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    return ma * ma + mb * mb + mc * mc;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic isect_t predict_isect(ray_t r);
    isect_t res;
    longint o[3], d[3], p[3], v[3], vn[3];
    logic [63:0] lv, lw, pp, bm, b2, h, sq, m;
    longint b, dot, t0, t1, t;
    logic [127:0] prod, q;
    res.hit = 1'b0;
    res.distance = '0;
    o[0] = signed'(r.ox); o[1] = signed'(r.oy); o[2] = signed'(r.oz);
    d[0] = signed'(r.dx); d[1] = signed'(r.dy); d[2] = signed'(r.dz);
    for (int i = 0; i < 3; i++) begin
      p[i] = xform_row(xform_regs[2*i], xform_regs[2*i+1], o[0], o[1], o[2], 1'b1);
      v[i] = xform_row(xform_regs[2*i], xform_regs[2*i+1], d[0], d[1], d[2], 1'b0);
    end
    lv = int_sqrt(mag_sq(v[0], v[1], v[2]));
    if (lv == 0) return res;   // degenerate direction counts as a miss
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      vn[i] = longint'((m << FRAC_BITS) / lv);
      if (v[i] < 0) vn[i] = -vn[i];
    end
    dot = vn[0] * p[0] + vn[1] * p[1] + vn[2] * p[2];
    b = dot >>> FRAC_BITS;
    if (b > 64'sh0_FFFF_FFFF) b = 64'sh0_FFFF_FFFF;
    if (b < -64'sh0_FFFF_FFFF) b = -64'sh0_FFFF_FFFF;
    bm = b < 0 ? -b : b;
    b2 = bm * bm;
    pp = mag_sq(p[0], p[1], p[2]);
    if (pp > b2) begin
      if (pp - b2 > ONE_SQ) return res;
      h = ONE_SQ - (pp - b2);
    end else begin
      h = b2 - pp;
      h = (h > ~64'd0 - ONE_SQ) ? ~64'd0 : h + ONE_SQ;
    end
    sq = int_sqrt(h);
    t0 = -b - longint'(sq);
    t1 = -b + longint'(sq);
    if (t1 < 0) return res;    // sphere lies behind the origin
    t = t0 >= 0 ? t0 : t1;     // inside the sphere: take the far root
    lw = int_sqrt(mag_sq(d[0], d[1], d[2]));
    prod = 128'(t) * 128'(lw);
    q = prod / 128'(lv);
    res.hit = 1'b1;
    res.distance = (q >= 128'h0FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0] + 32'd1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    if (idx < CFG_REGS) xform_regs[idx] = value;   // out-of-range writes are dropped
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load all six registers from a 3x3 matrix plus translation.
  task automatic load_xform(logic [31:0] m[9], logic [31:0] tr[3]);
    write_reg(CFG_M00_M01, {m[0], m[1]});
    write_reg(CFG_M02_TX,  {m[2], tr[0]});
    write_reg(CFG_M10_M11, {m[3], m[4]});
    write_reg(CFG_M12_TY,  {m[5], tr[1]});
    write_reg(CFG_M20_M21, {m[6], m[7]});
    write_reg(CFG_M22_TZ,  {m[8], tr[2]});
  endtask

  // Offer one ray and hold it until the transfer; valid stays up for the next ray.
  task automatic send_ray(ray_t r);
    if (sender_idle && $urandom_range(0, 6) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.origin_x = r.ox; in_if.origin_y = r.oy; in_if.origin_z = r.oz;
    in_if.dir_x = r.dx; in_if.dir_y = r.dy; in_if.dir_z = r.dz;
    do @(posedge clk); while (!in_if.ready);
    pending_hits.push_back(predict_isect(r));
    n_rays++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic ray_t mk_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  // Mostly rays aimed near the world origin with random scale; some raw noise.
  function automatic ray_t rand_ray();
    ray_t r;
    int o[3], tg[3], sh;
    if ($urandom_range(0, 9) < 2)
      return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    sh = $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      o[i] = $urandom_range(0, 524288) - 262144;
      tg[i] = $urandom_range(0, 131072) - 65536;
    end
    r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
    r.dx = (tg[0] - o[0]) >>> sh;
    r.dy = (tg[1] - o[1]) >>> sh;
    r.dz = (tg[2] - o[2]) >>> sh;
    return r;
  endfunction

  // Mild random affine map: diagonal 0.5..2.0 with random sign, small shear and shift.
  task automatic load_rand_xform();
    logic [31:0] m[9], tr[3];
    for (int i = 0; i < 9; i++) begin
      if (i % 4 == 0) begin
        m[i] = $urandom_range(32768, 131072);
        if ($urandom_range(0, 3) == 0) m[i] = -m[i];
      end else begin
        m[i] = $urandom_range(0, 16384) - 8192;
      end
    end
    for (int i = 0; i < 3; i++) tr[i] = $urandom_range(0, 131072) - 65536;
    load_xform(m, tr);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready bursts and the checker
  // ---------------------------------------------------------------------------

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        // long hold-off: count it down here so the sender keeps pushing
        out_if.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_if.ready = 1'b1;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    isect_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (out_if.hit) n_hit_results++;
      if (pending_hits.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result hit=%0b dist=%h", $realtime, out_if.hit,
                   out_if.distance);
      end else begin
        want = pending_hits.pop_front();
        if (out_if.hit !== want.hit || out_if.distance !== want.distance) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: mismatch hit exp=%0b got=%0b dist exp=%h got=%h", $realtime,
                     want.hit, out_if.hit, want.distance, out_if.distance);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identity transform after reset: edge geometry and coordinate extremes.
  task automatic test_directed_identity();
    logic [31:0] n1;
    n1 = -ONE;
    send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0));               // plain hit ahead
    send_ray(mk_ray(-2 * ONE, ONE, 0, ONE, 0, 0));             // tangent
    send_ray(mk_ray(0, 0, 0, 0, 0, ONE));                      // origin inside
    send_ray(mk_ray(ONE >> 2, 0, 0, n1, 0, 0));                // inside, off center
    send_ray(mk_ray(2 * ONE, 0, 0, ONE, 0, 0));                // sphere behind
    send_ray(mk_ray(-2 * ONE, 2 * ONE, 0, ONE, 0, 0));         // discriminant negative
    send_ray(mk_ray(-3 * ONE, 0, 0, 0, 0, 0));                 // zero direction
    send_ray(mk_ray(-2 * ONE, 0, 0, 1, 0, 0));                 // tiny direction
    send_ray(mk_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0)); // far origin, huge dir
    send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk_ray(-5 * ONE, -5 * ONE, -5 * ONE, ONE, ONE, ONE));
    send_ray(mk_ray('1, '1, '1, '1, '1, '1));
    send_ray(mk_ray(0, 0, 32'hFFF0_0000, 0, 0, 32'h7FFF_FFFF)); // origin at z = -16, huge dir
    drain();
  endtask

  // Register extremes: zero map, all-ones map, min/max entries, ignored indexes.
  task automatic test_register_extremes();
    logic [31:0] m[9], tr[3];
    foreach (m[i]) m[i] = '0;
    foreach (tr[i]) tr[i] = '0;
    load_xform(m, tr);
    send_ray(mk_ray(ONE, 0, 0, ONE, ONE, 0));                  // every direction maps to zero
    send_ray(rand_ray());
    drain();
    foreach (m[i]) m[i] = '1;
    foreach (tr[i]) tr[i] = '1;
    load_xform(m, tr);
    send_ray(mk_ray(ONE, 0, 0, ONE, 0, 0));
    send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0));
    drain();
    foreach (m[i]) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    foreach (tr[i]) tr[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    load_xform(m, tr);
    for (int i = 0; i < 6; i++) send_ray(rand_ray());
    drain();
    // back to identity, then writes beyond the register list must leave it alone
    foreach (m[i]) m[i] = (i % 4 == 0) ? ONE : 32'h0;
    foreach (tr[i]) tr[i] = '0;
    load_xform(m, tr);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0));
    drain();
  endtask

  task automatic test_random_xforms(int phases, int rays_per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      load_rand_xform();
      for (int i = 0; i < rays_per_phase; i++) send_ray(rand_ray());
      drain();
    end
  endtask

  // Stall the result side long enough to fill the pipe and back up the input.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 300; i++) send_ray(rand_ray());
    drain();
  endtask

  // Full-range register contents with raw noise rays.
  task automatic test_random_registers();
    for (int ph = 0; ph < 2; ph++) begin
      for (int k = 0; k < CFG_REGS; k++) write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
      for (int i = 0; i < 40; i++)
        send_ray(mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      drain();
    end
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_full_rate();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    load_rand_xform();
    for (int i = 0; i < 150; i++) send_ray(rand_ray());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.origin_x = '0; in_if.origin_y = '0; in_if.origin_z = '0;
    in_if.dir_x = '0; in_if.dir_y = '0; in_if.dir_z = '0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    hold_cycles = 0;
    n_rays = 0;
    n_results = 0;
    n_hit_results = 0;
    n_mismatch = 0;
    xform_regs[CFG_M00_M01] = RST_M00_M01;
    xform_regs[CFG_M02_TX]  = RST_M02_TX;
    xform_regs[CFG_M10_M11] = RST_M10_M11;
    xform_regs[CFG_M12_TY]  = RST_M12_TY;
    xform_regs[CFG_M20_M21] = RST_M20_M21;
    xform_regs[CFG_M22_TZ]  = RST_M22_TZ;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_identity();
    test_register_extremes();
    test_random_xforms(5, 180);
    test_backpressure();
    test_random_registers();
    test_full_rate();

    // let any stray result surface before the verdict
    repeat (LATENCY + 20) @(negedge clk);
    $display("Sent %0d rays under many inverse transforms; %0d results, %0d hits, %0d bad.",
             n_rays, n_results, n_hit_results, n_mismatch);
    if (n_mismatch == 0 && pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
